FILE: sv/spq_pkg.sv
`default_nettype none
package spq_pkg;

  // Operation codes carried on op_i
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_PEEK   = 2'd2;

  // Fixed field widths of the ports
  localparam int ITEM_W      = 32;
  localparam int PRIO_W      = 16;
  localparam int OUT_COUNT_W = 7;

  // Per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic ins;
    logic rem;
  } cell_cmd_t;

endpackage
`default_nettype wire

FILE: sv/sorted_priority_queue.sv
`default_nettype none
// Min-first sorted priority queue built as a chain of CAPACITY compare-and-shift
// cells, cell 0 holding the head. Every accepted transaction (insert, remove
// head, peek head) is applied to the whole chain at once: each cell
// compares its key with the new key and takes its own, its neighbor's or the
// new entry, so one operation is accepted per cycle unless the input is
// stalled, and its status appears in the output register on the next cycle.
// The input is stalled only while that output register holds a result that
// the receiver stalls. Among equal keys the newest entry is served first; an
// insert into a full queue is dropped and reported with overflow_o.
module sorted_priority_queue #(
  parameter int CAPACITY  = 64,
  parameter int KEY_WIDTH = 16
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               in_valid_i,
  output logic                              in_stall_o,
  input  wire [1:0]                         op_i,
  input  wire [spq_pkg::ITEM_W-1:0]         item_handle_i,
  input  wire signed [spq_pkg::PRIO_W-1:0]  priority_req_i,
  output logic                              out_valid_o,
  input  wire                               out_stall_i,
  output logic [spq_pkg::ITEM_W-1:0]        item_out_o,
  output logic                              item_valid_o,
  output logic                              overflow_o,
  output logic                              is_empty_o,
  output logic [spq_pkg::OUT_COUNT_W-1:0]   entry_count_o
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic signed [32:0] KEY_HI = (33'sd1 <<< (KEY_WIDTH - 1)) - 33'sd1;
  localparam logic signed [32:0] KEY_LO = -KEY_HI - 33'sd1;

  logic                         accept;
  logic                         full;
  spq_pkg::cell_cmd_t           cmd;
  logic signed [32:0]           prio_ext;
  logic signed [32:0]           prio_sat;
  logic signed [KEY_WIDTH-1:0]  new_key;

  logic [CW-1:0]                cnt_q, cnt_d;
  logic [CAPACITY-1:0]          cell_valid;
  logic [CAPACITY-1:0]          cell_keep;
  logic signed [KEY_WIDTH-1:0]  cell_key  [CAPACITY];
  logic [spq_pkg::ITEM_W-1:0]   cell_item [CAPACITY];

  logic                         out_valid_q;
  logic [spq_pkg::ITEM_W-1:0]   item_q, item_d;
  logic                         item_valid_q, item_valid_d;
  logic                         ovf_q, ovf_d;
  logic                         empty_q;
  logic [CW-1:0]                count_q;
  logic [CW+spq_pkg::OUT_COUNT_W-1:0] count_ext;

  // Handshake: output register frees up when its result is taken
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign full       = (cnt_q == CW'(CAPACITY));

  // Saturate the request key into the stored key range
  assign prio_ext = 33'(priority_req_i);
  always_comb begin
    if (prio_ext > KEY_HI) begin
      prio_sat = KEY_HI;
    end else if (prio_ext < KEY_LO) begin
      prio_sat = KEY_LO;
    end else begin
      prio_sat = prio_ext;
    end
  end
  assign new_key = prio_sat[KEY_WIDTH-1:0];

  // Broadcast command to the chain
  assign cmd.ins = accept && (op_i == spq_pkg::OP_INSERT) && !full;
  assign cmd.rem = accept && (op_i == spq_pkg::OP_REMOVE) && (cnt_q != '0);

  // Chain of cells, head at index 0
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                        prev_keep;
    logic                        prev_valid;
    logic signed [KEY_WIDTH-1:0] prev_key;
    logic [spq_pkg::ITEM_W-1:0]  prev_item;
    logic                        next_valid;
    logic signed [KEY_WIDTH-1:0] next_key;
    logic [spq_pkg::ITEM_W-1:0]  next_item;

    if (i == 0) begin : g_head
      assign prev_keep  = 1'b1;
      assign prev_valid = 1'b0;
      assign prev_key   = '0;
      assign prev_item  = '0;
    end else begin : g_mid
      assign prev_keep  = cell_keep[i-1];
      assign prev_valid = cell_valid[i-1];
      assign prev_key   = cell_key[i-1];
      assign prev_item  = cell_item[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_valid = 1'b0;
      assign next_key   = '0;
      assign next_item  = '0;
    end else begin : g_body
      assign next_valid = cell_valid[i+1];
      assign next_key   = cell_key[i+1];
      assign next_item  = cell_item[i+1];
    end

    spq_cell #(
      .KEY_WIDTH (KEY_WIDTH)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .new_key_i    (new_key),
      .new_item_i   (item_handle_i),
      .prev_keep_i  (prev_keep),
      .prev_valid_i (prev_valid),
      .prev_key_i   (prev_key),
      .prev_item_i  (prev_item),
      .next_valid_i (next_valid),
      .next_key_i   (next_key),
      .next_item_i  (next_item),
      .keep_o       (cell_keep[i]),
      .valid_o      (cell_valid[i]),
      .key_o        (cell_key[i]),
      .item_o       (cell_item[i])
    );
  end

  // Advance the fill count
  always_comb begin
    cnt_d = cnt_q;
    if (cmd.ins) begin
      cnt_d = cnt_q + CW'(1);
    end else if (cmd.rem) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Status of the accepted transaction
  always_comb begin
    item_d       = '0;
    item_valid_d = 1'b0;
    ovf_d        = 1'b0;
    unique case (op_i)
      spq_pkg::OP_INSERT: begin
        item_valid_d = 1'b1;
        if (full) begin
          ovf_d  = 1'b1;
          item_d = cell_item[0];
        end else if (cell_keep[0]) begin
          item_d = cell_item[0];
        end else begin
          item_d = item_handle_i;
        end
      end
      spq_pkg::OP_REMOVE, spq_pkg::OP_PEEK: begin
        item_valid_d = cell_valid[0];
        item_d       = cell_valid[0] ? cell_item[0] : '0;
      end
      default: begin
        item_d = '0;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q       <= item_d;
      item_valid_q <= item_valid_d;
      ovf_q        <= ovf_d;
      empty_q      <= (cnt_d == '0);
      count_q      <= cnt_d;
    end
  end

  assign count_ext     = {{spq_pkg::OUT_COUNT_W{1'b0}}, count_q};
  assign out_valid_o   = out_valid_q;
  assign item_out_o    = item_q;
  assign item_valid_o  = item_valid_q;
  assign overflow_o    = ovf_q;
  assign is_empty_o    = empty_q;
  assign entry_count_o = count_ext[spq_pkg::OUT_COUNT_W-1:0];

  // Occupied cells form an unbroken run from the head
  a_valid_contig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cell_valid >> 1) & ~cell_valid) == '0)
    else $error("occupied cells not contiguous");

  // Fill count tracks the number of occupied cells
  a_count_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(cell_valid) == int'(cnt_q))
    else $error("fill count disagrees with cell occupancy");

  // A pending overflow result implies the queue is still full
  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && ovf_q) |-> (full && count_q == CW'(CAPACITY)))
    else $error("overflow reported while queue not full");

  // A removal from a non-empty queue lowers the fill count by one
  a_remove_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rem |=> (cnt_q == $past(cnt_q) - CW'(1)))
    else $error("remove did not lower the fill count");

endmodule
`default_nettype wire

FILE: sv/spq_cell.sv
`default_nettype none
module spq_cell #(
  parameter int KEY_WIDTH = 16
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  spq_pkg::cell_cmd_t            cmd_i,
  input  wire signed [KEY_WIDTH-1:0]    new_key_i,
  input  wire [spq_pkg::ITEM_W-1:0]     new_item_i,
  input  wire                           prev_keep_i,
  input  wire                           prev_valid_i,
  input  wire signed [KEY_WIDTH-1:0]    prev_key_i,
  input  wire [spq_pkg::ITEM_W-1:0]     prev_item_i,
  input  wire                           next_valid_i,
  input  wire signed [KEY_WIDTH-1:0]    next_key_i,
  input  wire [spq_pkg::ITEM_W-1:0]     next_item_i,
  output logic                          keep_o,
  output logic                          valid_o,
  output logic signed [KEY_WIDTH-1:0]   key_o,
  output logic [spq_pkg::ITEM_W-1:0]    item_o
);

  logic                        valid_q, valid_d;
  logic signed [KEY_WIDTH-1:0] key_q, key_d;
  logic [spq_pkg::ITEM_W-1:0]  item_q, item_d;

  // Stored entry strictly smaller than the new key stays in place
  assign keep_o = valid_q && (key_q < new_key_i);

  // Hold, take the new entry, shift down from the previous cell, or shift up
  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    item_d  = item_q;
    if (cmd_i.ins && !keep_o) begin
      if (prev_keep_i) begin
        valid_d = 1'b1;
        key_d   = new_key_i;
        item_d  = new_item_i;
      end else begin
        valid_d = prev_valid_i;
        key_d   = prev_key_i;
        item_d  = prev_item_i;
      end
    end else if (cmd_i.rem) begin
      valid_d = next_valid_i;
      key_d   = next_key_i;
      item_d  = next_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    item_q <= item_d;
  end

  assign valid_o = valid_q;
  assign key_o   = key_q;
  assign item_o  = item_q;

endmodule
`default_nettype wire

FILE: dv/sorted_priority_queue_tb.sv
`default_nettype none
module sorted_priority_queue_tb;

  localparam int CAPACITY    = 64;
  localparam int KEY_WIDTH   = 16;
  localparam int ITEM_W      = spq_pkg::ITEM_W;
  localparam int PRIO_W      = spq_pkg::PRIO_W;
  localparam int OUT_COUNT_W = spq_pkg::OUT_COUNT_W;
  localparam logic [1:0] OP_NOP = 2'd3;  // unused code, performs no operation
  localparam int NUM_RANDOM  = 1200;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 16;

  typedef struct {
    logic [1:0]               op;
    logic [ITEM_W-1:0]        handle;
    logic signed [PRIO_W-1:0] prio;
    bit                       wait_drain;  // hold off until the queue of results is empty
  } pq_op_t;

  typedef struct {
    logic [ITEM_W-1:0]      item;
    logic                   item_valid;
    logic                   overflow;
    logic                   is_empty;
    logic [OUT_COUNT_W-1:0] count;
  } pq_status_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic [1:0]               op_i = OP_NOP;
  logic [ITEM_W-1:0]        item_handle_i = '0;
  logic signed [PRIO_W-1:0] priority_req_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic [ITEM_W-1:0]        item_out_o;
  logic                     item_valid_o;
  logic                     overflow_o;
  logic                     is_empty_o;
  logic [OUT_COUNT_W-1:0]   entry_count_o;

  pq_op_t     pending_ops[$];
  pq_status_t expected_status[$];
  int         n_total;
  int         n_accepted = 0;
  int         n_checked = 0;
  int         mismatches = 0;
  int         burst_left = 0;
  int         gap_left = 0;
  int         cycle_count = 0;
  logic [15:0] stall_cycle = '0;

  // Shadow copy of the sorted chain
  logic [ITEM_W-1:0] mdl_item[CAPACITY];
  int                mdl_key[CAPACITY];
  int                mdl_fill = 0;

  sorted_priority_queue #(
    .CAPACITY (CAPACITY),
    .KEY_WIDTH(KEY_WIDTH)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .item_handle_i (item_handle_i),
    .priority_req_i(priority_req_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .item_out_o    (item_out_o),
    .item_valid_o  (item_valid_o),
    .overflow_o    (overflow_o),
    .is_empty_o    (is_empty_o),
    .entry_count_o (entry_count_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Sign-extend the request key, then saturate to the stored key width
  function automatic int clamp_key(logic signed [PRIO_W-1:0] raw);
    longint k;
    longint hi;
    longint lo;
    k  = raw;
    hi = (longint'(1) << (KEY_WIDTH - 1)) - 1;
    lo = -hi - 1;
    if (k > hi) k = hi;
    if (k < lo) k = lo;
    return int'(k);
  endfunction

  // Apply one transaction to the shadow chain and return its status
  function automatic pq_status_t apply_queue_op(pq_op_t t);
    pq_status_t s;
    int key;
    int pos;
    s.item       = '0;
    s.item_valid = 1'b0;
    s.overflow   = 1'b0;
    case (t.op)
      spq_pkg::OP_INSERT: begin
        if (mdl_fill >= CAPACITY) begin
          s.overflow = 1'b1;
        end else begin
          key = clamp_key(t.prio);
          pos = 0;
          // newest entry goes ahead of equal keys
          while (pos < mdl_fill && mdl_key[pos] < key) pos++;
          for (int i = mdl_fill; i > pos; i--) begin
            mdl_item[i] = mdl_item[i-1];
            mdl_key[i]  = mdl_key[i-1];
          end
          mdl_item[pos] = t.handle;
          mdl_key[pos]  = key;
          mdl_fill++;
        end
        if (mdl_fill > 0) begin
          s.item       = mdl_item[0];
          s.item_valid = 1'b1;
        end
      end
      spq_pkg::OP_REMOVE: begin
        if (mdl_fill > 0) begin
          s.item       = mdl_item[0];
          s.item_valid = 1'b1;
          for (int i = 1; i < mdl_fill; i++) begin
            mdl_item[i-1] = mdl_item[i];
            mdl_key[i-1]  = mdl_key[i];
          end
          mdl_fill--;
        end
      end
      spq_pkg::OP_PEEK: begin
        if (mdl_fill > 0) begin
          s.item       = mdl_item[0];
          s.item_valid = 1'b1;
        end
      end
      default: ;
    endcase
    s.is_empty = (mdl_fill == 0);
    s.count    = OUT_COUNT_W'(mdl_fill);
    return s;
  endfunction

  // Tight keys in nearly half of the picks so ties are common, with extremes and full-range values mixed in
  function automatic logic signed [PRIO_W-1:0] pick_key();
    int r;
    int v;
    r = $urandom_range(99, 0);
    if (r < 45) v = int'($urandom_range(8, 0)) - 4;
    else if (r < 60) v = ($urandom_range(1, 0) != 0) ? 32767 : -32768;
    else if (r < 80) v = int'($urandom_range(511, 0)) - 256;
    else v = int'($urandom);
    return PRIO_W'(v);
  endfunction

  function automatic logic [ITEM_W-1:0] pick_handle();
    int r;
    r = $urandom_range(99, 0);
    if (r < 10) return '0;
    if (r < 20) return '1;
    return $urandom;
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(9, 0) < 4) return 0;
    return $urandom_range(8, 1);
  endfunction

  task automatic queue_op(logic [1:0] op, logic [ITEM_W-1:0] handle, int prio, bit hold);
    pq_op_t t;
    t.op         = op;
    t.handle     = handle;
    t.prio       = PRIO_W'(prio);
    t.wait_drain = hold;
    pending_ops.push_back(t);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Driver: present queued transactions in bursts, hold while stalled
  always @(posedge clk_i or negedge rst_ni) begin
    pq_op_t taken;
    pq_op_t nxt;
    bit     fire;
    int     acc_now;
    if (!rst_ni) begin
      in_valid_i     <= 1'b0;
      op_i           <= OP_NOP;
      item_handle_i  <= '0;
      priority_req_i <= '0;
      burst_left     <= 0;
      gap_left       <= 0;
    end else begin
      fire = in_valid_i && !in_stall_o;
      if (fire) begin
        taken.op         = op_i;
        taken.handle     = item_handle_i;
        taken.prio       = priority_req_i;
        taken.wait_drain = 1'b0;
        expected_status.push_back(apply_queue_op(taken));
      end
      acc_now = n_accepted + (fire ? 1 : 0);
      n_accepted <= acc_now;

      if (in_valid_i && !fire) begin
        // stalled: hold payload
      end else if (gap_left > 0) begin
        in_valid_i <= 1'b0;
        gap_left   <= gap_left - 1;
      end else if (pending_ops.size() != 0 &&
                   (!pending_ops[0].wait_drain || acc_now == n_checked)) begin
        nxt = pending_ops.pop_front();
        in_valid_i     <= 1'b1;
        op_i           <= nxt.op;
        item_handle_i  <= nxt.handle;
        priority_req_i <= nxt.prio;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(64, 1);
          gap_left   <= pick_gap();
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver stall: rotate between no stall, light, heavy and a fixed toggle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_cycle <= '0;
    end else begin
      stall_cycle <= stall_cycle + 16'd1;
      case (stall_cycle[8:7])
        2'd0:    out_stall_i <= 1'b0;
        2'd1:    out_stall_i <= ($urandom_range(3, 0) == 0);
        2'd2:    out_stall_i <= ($urandom_range(3, 0) != 0);
        default: out_stall_i <= stall_cycle[1];
      endcase
    end
  end

  // Monitor: compare each result transaction with the oldest prediction
  always @(posedge clk_i) begin
    pq_status_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_status.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual item %h count %0d",
                 $time, item_out_o, entry_count_o);
        mismatches++;
      end else begin
        want = expected_status.pop_front();
        check_field("item_out", want.item, item_out_o);
        check_field("item_valid", 32'(want.item_valid), 32'(item_valid_o));
        check_field("overflow", 32'(want.overflow), 32'(overflow_o));
        check_field("is_empty", 32'(want.is_empty), 32'(is_empty_o));
        check_field("entry_count", 32'(want.count), 32'(entry_count_o));
        n_checked <= n_checked + 1;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    pq_op_t t;
    int     n_random;
    int     phase_len;
    int     ins_pct;
    int     rem_pct;
    int     roll;

    // Directed: empty-queue cases, key extremes, ties, unused op code
    queue_op(spq_pkg::OP_PEEK, 32'h1234_5678, 0, 1'b0);
    queue_op(spq_pkg::OP_REMOVE, 32'h8765_4321, -1, 1'b0);
    queue_op(OP_NOP, 32'hFFFF_FFFF, -32768, 1'b0);
    queue_op(spq_pkg::OP_INSERT, 32'hFFFF_FFFF, 32767, 1'b0);
    queue_op(spq_pkg::OP_INSERT, 32'h0000_0000, -32768, 1'b0);
    queue_op(spq_pkg::OP_INSERT, 32'hA5A5_A5A5, 0, 1'b0);
    queue_op(spq_pkg::OP_INSERT, 32'h5A5A_5A5A, 0, 1'b0);
    queue_op(spq_pkg::OP_INSERT, 32'h0000_0001, -32768, 1'b0);
    queue_op(spq_pkg::OP_INSERT, 32'h0000_0002, 32767, 1'b0);
    queue_op(spq_pkg::OP_PEEK, 32'hDEAD_BEEF, 5, 1'b1);
    queue_op(OP_NOP, 32'h0F0F_0F0F, 32767, 1'b0);
    repeat (6) queue_op(spq_pkg::OP_REMOVE, 32'h0, 0, 1'b0);
    queue_op(spq_pkg::OP_REMOVE, 32'hFFFF_FFFF, 32767, 1'b0);
    queue_op(spq_pkg::OP_PEEK, 32'h0, 0, 1'b0);
    queue_op(OP_NOP, 32'h0, 0, 1'b0);

    // Random: phases biased toward filling, draining or mixing
    n_random = 0;
    while (n_random < NUM_RANDOM) begin
      phase_len = $urandom_range(150, 30);
      case ($urandom_range(2, 0))
        0:       begin ins_pct = 85; rem_pct = 10; end
        1:       begin ins_pct = 10; rem_pct = 80; end
        default: begin ins_pct = 45; rem_pct = 40; end
      endcase
      for (int j = 0; j < phase_len; j++) begin
        roll = $urandom_range(99, 0);
        if (roll < ins_pct) t.op = spq_pkg::OP_INSERT;
        else if (roll < ins_pct + rem_pct) t.op = spq_pkg::OP_REMOVE;
        else if (roll < 97) t.op = spq_pkg::OP_PEEK;
        else t.op = OP_NOP;
        t.handle     = pick_handle();
        t.prio       = pick_key();
        t.wait_drain = (j == 0) && ($urandom_range(3, 0) == 0);
        pending_ops.push_back(t);
        n_random++;
      end
    end
    n_total = pending_ops.size();

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every result, then a short tail for stray results
    do @(posedge clk_i); while (n_checked != n_total);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && expected_status.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire
